@@ src/bdq_pkg.sv @@
// Package for the bounded deque with erase: operation codes, field widths
// and the result record passed from the sequencer to the top level.
// No dependencies.
package bdq_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int FUNC_W  = 2;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;

  localparam logic [FUNC_W-1:0] FN_APPEND  = 2'd0;
  localparam logic [FUNC_W-1:0] FN_PREPEND = 2'd1;
  localparam logic [FUNC_W-1:0] FN_POP     = 2'd2;
  localparam logic [FUNC_W-1:0] FN_ERASE   = 2'd3;

  typedef struct packed {
    logic                      is_empty;
    logic [COUNT_W-1:0]        count_after;
    logic                      insert_rejected;
    logic                      erase_found;
    logic signed [VALUE_W-1:0] popped_value;
  } bdq_res_t;

endpackage

@@ src/bounded_deque_with_erase.sv @@
// Top level of the bounded deque with erase: stream ports, output register,
// sequencer and entry store. Depends on bdq_pkg, bdq_seq and bdq_mem.
//
//   Channel  Direction  Contents
//   in_      slave      tuser: func; tdata: item_value
//   out_     master     tdata: popped_value, erase_found, insert_rejected,
//                       count_after, is_empty
//
// One transaction is processed at a time. Append and prepend write the store in
// the execute state; pop reads the front entry and takes the read data in a
// second state (skipped on an empty store); erase runs a search-and-compact pass
// that reads one entry of the store per cycle (skipped on an empty store). The
// result reaches out_tvalid in the same cycle as in_tready rises for the next
// input. Reset clears the front index and the count; the store itself needs no
// clearing. A result waiting in the output register does not block acceptance
// of the next input transaction, but that transaction's result holds the
// sequencer until the register drains.
module bounded_deque_with_erase #(
  parameter int CAPACITY = bdq_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] item_value
  input  logic [1:0]  in_tuser,   // [1:0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [31:0] popped_value, [32] erase_found,
                                  // [33] insert_rejected, [38:34] count_after,
                                  // [39] is_empty
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic                        res_valid;
  logic                        res_ready;
  bdq_pkg::bdq_res_t           res;
  logic                        mem_we;
  logic [IDX_W-1:0]            mem_waddr;
  logic [bdq_pkg::VALUE_W-1:0] mem_wdata;
  logic                        mem_re;
  logic [IDX_W-1:0]            mem_raddr;
  logic [bdq_pkg::VALUE_W-1:0] mem_rdata;

  logic                        out_valid_r, out_valid_nxt;
  bdq_pkg::bdq_res_t           out_data_r, out_data_nxt;

  bdq_seq #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W),
    .CNT_W    (CNT_W)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_func   (in_tuser),
    .in_value  (in_tdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  bdq_mem #(
    .DEPTH  (CAPACITY),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ src/bdq_mem.sv @@
// Entry store of the bounded deque: one write port and one read port with
// registered read data.
// Uses bdq_pkg for the data width.
module bdq_mem #(
  parameter int DEPTH  = bdq_pkg::CAPACITY_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [ADDR_W-1:0]            waddr,
  input  logic [bdq_pkg::VALUE_W-1:0]  wdata,
  input  logic                         re,
  input  logic [ADDR_W-1:0]            raddr,
  output logic [bdq_pkg::VALUE_W-1:0]  rdata
);

  logic [bdq_pkg::VALUE_W-1:0] mem [DEPTH];
  logic [bdq_pkg::VALUE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/bdq_seq.sv @@
// Sequencer of the bounded deque: holds front index and count, drives the
// entry store and runs the search-and-compact pass of erase.
// Uses bdq_pkg for operation codes and the result record.
module bdq_seq #(
  parameter int CAPACITY = bdq_pkg::CAPACITY_DEF,
  parameter int IDX_W    = $clog2(CAPACITY),
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [bdq_pkg::FUNC_W-1:0]     in_func,
  input  logic [bdq_pkg::VALUE_W-1:0]    in_value,
  output logic                           res_valid,
  input  logic                           res_ready,
  output bdq_pkg::bdq_res_t              res,
  output logic                           mem_we,
  output logic [IDX_W-1:0]               mem_waddr,
  output logic [bdq_pkg::VALUE_W-1:0]    mem_wdata,
  output logic                           mem_re,
  output logic [IDX_W-1:0]               mem_raddr,
  input  logic [bdq_pkg::VALUE_W-1:0]    mem_rdata
);

  localparam int SUM_W = CNT_W + 1;
  localparam logic [SUM_W-1:0] CAP_S   = SUM_W'(CAPACITY);
  localparam logic [CNT_W-1:0] CAP_C   = CNT_W'(CAPACITY);
  localparam logic [IDX_W-1:0] LAST_IX = IDX_W'(CAPACITY - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_POPRD = 3'd2;
  localparam logic [2:0] S_ERASE = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  logic [2:0]                  state_r, state_nxt;
  logic [IDX_W-1:0]            front_r, front_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic [bdq_pkg::FUNC_W-1:0]  func_r, func_nxt;
  logic [bdq_pkg::VALUE_W-1:0] val_r, val_nxt;
  logic [bdq_pkg::VALUE_W-1:0] pop_r, pop_nxt;
  logic                        found_r, found_nxt;
  logic                        rej_r, rej_nxt;
  logic [CNT_W-1:0]            rd_pos_r, rd_pos_nxt;
  logic                        chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]            chk_slot_r, chk_slot_nxt;
  logic                        hit_r, hit_nxt;

  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] f,
                                               input logic [CNT_W-1:0] p);
    logic [SUM_W-1:0] s;
    s = SUM_W'(f) + SUM_W'(p);
    if (s >= CAP_S) begin
      s = s - CAP_S;
    end
    return s[IDX_W-1:0];
  endfunction

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_RESP);

  always_comb begin
    res.popped_value    = pop_r;
    res.erase_found     = found_r;
    res.insert_rejected = rej_r;
    res.count_after     = bdq_pkg::COUNT_W'(count_r);
    res.is_empty        = (count_r == '0);
  end

  always_comb begin
    state_nxt    = state_r;
    front_nxt    = front_r;
    count_nxt    = count_r;
    func_nxt     = func_r;
    val_nxt      = val_r;
    pop_nxt      = pop_r;
    found_nxt    = found_r;
    rej_nxt      = rej_r;
    rd_pos_nxt   = rd_pos_r;
    chk_vld_nxt  = chk_vld_r;
    chk_slot_nxt = chk_slot_r;
    hit_nxt      = hit_r;
    mem_we       = 1'b0;
    mem_waddr    = front_r;
    mem_wdata    = val_r;
    mem_re       = 1'b0;
    mem_raddr    = front_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt  = in_func;
          val_nxt   = in_value;
          pop_nxt   = '0;
          found_nxt = 1'b0;
          rej_nxt   = 1'b0;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_RESP;
        unique case (func_r)
          bdq_pkg::FN_APPEND: begin
            if (count_r == CAP_C) begin
              rej_nxt = 1'b1;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = slot_of(front_r, count_r);
              count_nxt = count_r + 1'b1;
            end
          end
          bdq_pkg::FN_PREPEND: begin
            if (count_r == CAP_C) begin
              rej_nxt = 1'b1;
            end else begin
              front_nxt = (front_r == '0) ? LAST_IX : front_r - 1'b1;
              mem_we    = 1'b1;
              mem_waddr = front_nxt;
              count_nxt = count_r + 1'b1;
            end
          end
          bdq_pkg::FN_POP: begin
            if (count_r != '0) begin
              mem_re    = 1'b1;
              state_nxt = S_POPRD;
            end
          end
          bdq_pkg::FN_ERASE: begin
            if (count_r != '0) begin
              rd_pos_nxt  = '0;
              chk_vld_nxt = 1'b0;
              hit_nxt     = 1'b0;
              state_nxt   = S_ERASE;
            end
          end
          default: begin
          end
        endcase
      end
      S_POPRD: begin
        pop_nxt   = mem_rdata;
        front_nxt = (front_r == LAST_IX) ? '0 : front_r + 1'b1;
        count_nxt = count_r - 1'b1;
        state_nxt = S_RESP;
      end
      S_ERASE: begin
        if (rd_pos_r < count_r) begin
          mem_re       = 1'b1;
          mem_raddr    = slot_of(front_r, rd_pos_r);
          rd_pos_nxt   = rd_pos_r + 1'b1;
          chk_vld_nxt  = 1'b1;
          chk_slot_nxt = mem_raddr;
        end else begin
          chk_vld_nxt = 1'b0;
        end
        if (chk_vld_r) begin
          if (hit_r) begin
            mem_we    = 1'b1;
            mem_waddr = (chk_slot_r == '0) ? LAST_IX : chk_slot_r - 1'b1;
            mem_wdata = mem_rdata;
          end else if (mem_rdata == val_r) begin
            hit_nxt = 1'b1;
          end
        end else if (rd_pos_r == count_r) begin
          found_nxt = hit_r;
          if (hit_r) begin
            count_nxt = count_r - 1'b1;
          end
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      front_r   <= '0;
      count_r   <= '0;
      chk_vld_r <= 1'b0;
      hit_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      front_r   <= front_nxt;
      count_r   <= count_nxt;
      chk_vld_r <= chk_vld_nxt;
      hit_r     <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    val_r      <= val_nxt;
    pop_r      <= pop_nxt;
    found_r    <= found_nxt;
    rej_r      <= rej_nxt;
    rd_pos_r   <= rd_pos_nxt;
    chk_slot_r <= chk_slot_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_C)
    else $error("Entry count exceeds capacity.");

  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_EXEC || (state_r == S_ERASE && hit_r)))
    else $error("Store written outside an insert or a compaction step.");

  a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_RESP) |=> $stable(count_r))
    else $error("Entry count changed while no operation was running.");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !(res.erase_found && res.insert_rejected))
    else $error("Erase and reject flags set together.");

  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && func_r != bdq_pkg::FN_POP) |-> (res.popped_value == '0))
    else $error("Popped value set by an operation other than pop.");

endmodule
